// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file lc3b_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLKED(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/lc3b_pkg.sv
`default_nettype none

package lc3b_pkg;

    localparam int WORD_W     = 16;
    localparam int CW_W       = 35;
    localparam int STATE_W    = 6;
    localparam int REG_COUNT  = 8;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int RF_READS   = 3;
    localparam int CC_W       = 3;

    localparam logic [CC_W-1:0] CC_N = 3'b100;
    localparam logic [CC_W-1:0] CC_Z = 3'b010;
    localparam logic [CC_W-1:0] CC_P = 3'b001;

    localparam logic [1:0] COND_READY = 2'd1;
    localparam logic [1:0] COND_BEN   = 2'd2;
    localparam logic [1:0] COND_IR11  = 2'd3;

    localparam logic [1:0] ADDR2_ZERO = 2'd0;
    localparam logic [1:0] ADDR2_OFF6 = 2'd1;
    localparam logic [1:0] ADDR2_OFF9 = 2'd2;

    localparam logic [1:0] PCMUX_INC = 2'd0;
    localparam logic [1:0] PCMUX_BUS = 2'd1;

    localparam logic [1:0] ALUK_ADD  = 2'd0;
    localparam logic [1:0] ALUK_AND  = 2'd1;
    localparam logic [1:0] ALUK_XOR  = 2'd2;

    // read port order of the register file
    localparam int RD_BASE = 0;  // IR[8:6]
    localparam int RD_DST  = 1;  // IR[11:9]
    localparam int RD_SR2  = 2;  // IR[2:0]

    typedef struct packed {
        logic              ird;
        logic [1:0]        cond;
        logic [STATE_W-1:0] j;
        logic              ld_mar;
        logic              ld_mdr;
        logic              ld_ir;
        logic              ld_ben;
        logic              ld_reg;
        logic              ld_cc;
        logic              ld_pc;
        logic              drive_pc;
        logic              drive_mdr;
        logic              drive_alu;
        logic              drive_marmux;
        logic              drive_shf;
        logic [1:0]        pcmux;
        logic              drmux;
        logic              sr1mux;
        logic              addr1mux;
        logic [1:0]        addr2mux;
        logic              marmux;
        logic [1:0]        aluk;
        logic              mio_en;
        logic              r_w;
        logic              word_op;
        logic              lshf1;
    } ctrl_t;

    typedef struct packed {
        logic [WORD_W-1:0]  pc;
        logic [WORD_W-1:0]  ir;
        logic [WORD_W-1:0]  mar;
        logic [WORD_W-1:0]  mdr;
        logic [CC_W-1:0]    cc;
        logic               ben;
        logic               rf_we;
        logic [REG_AW-1:0]  rf_waddr;
        logic [STATE_W-1:0] next_upc;
        logic [WORD_W-1:0]  bus;
        logic [WORD_W-1:0]  wdata;
        logic               we_lo;
        logic               we_hi;
    } upd_t;

    function automatic ctrl_t decode_cw(input logic [CW_W-1:0] cw);
        ctrl_t c;
        c.ird          = cw[0];
        c.cond         = {cw[1], cw[2]};
        c.j            = {cw[3], cw[4], cw[5], cw[6], cw[7], cw[8]};
        c.ld_mar       = cw[9];
        c.ld_mdr       = cw[10];
        c.ld_ir        = cw[11];
        c.ld_ben       = cw[12];
        c.ld_reg       = cw[13];
        c.ld_cc        = cw[14];
        c.ld_pc        = cw[15];
        c.drive_pc     = cw[16];
        c.drive_mdr    = cw[17];
        c.drive_alu    = cw[18];
        c.drive_marmux = cw[19];
        c.drive_shf    = cw[20];
        c.pcmux        = {cw[21], cw[22]};
        c.drmux        = cw[23];
        c.sr1mux       = cw[24];
        c.addr1mux     = cw[25];
        c.addr2mux     = {cw[26], cw[27]};
        c.marmux       = cw[28];
        c.aluk         = {cw[29], cw[30]};
        c.mio_en       = cw[31];
        c.r_w          = cw[32];
        c.word_op      = cw[33];
        c.lshf1        = cw[34];
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lc3b_ram.sv
`default_nettype none

module lc3b_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/lc3b_regfile.sv
`default_nettype none

module lc3b_regfile (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          we,
    input  wire [lc3b_pkg::REG_AW-1:0]   waddr,
    input  wire [lc3b_pkg::WORD_W-1:0]   wdata,
    input  wire [lc3b_pkg::REG_AW-1:0]   raddr [lc3b_pkg::RF_READS],
    output logic [lc3b_pkg::WORD_W-1:0]  rdata [lc3b_pkg::RF_READS]
);
    import lc3b_pkg::*;

    logic [REG_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]    wdata_reg;
    logic [RF_READS-1:0]  rvalid_reg;
    logic [RF_READS-1:0]  bypass_reg;
    logic [WORD_W-1:0]    ram_q [RF_READS];

    // one copy per read port, all written together
    for (genvar k = 0; k < RF_READS; k++) begin : g_port
        logic hit;
        assign hit = we && (waddr == raddr[k]);

        lc3b_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (raddr[k]),
            .rdata (ram_q[k])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rvalid_reg[k] <= 1'b0;
                bypass_reg[k] <= 1'b0;
            end else begin
                rvalid_reg[k] <= valid_reg[raddr[k]] || hit;
                bypass_reg[k] <= hit;
            end
        end

        assign rdata[k] = !rvalid_reg[k] ? '0 :
                          bypass_reg[k]  ? wdata_reg : ram_q[k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
        wdata_reg <= wdata;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lc3b_exec.sv
`default_nettype none

module lc3b_exec (
    input  lc3b_pkg::ctrl_t               ctrl,
    input  wire [lc3b_pkg::WORD_W-1:0]    mem_rd,
    input  wire                           mem_rdy,
    input  wire [lc3b_pkg::WORD_W-1:0]    pc,
    input  wire [lc3b_pkg::WORD_W-1:0]    ir,
    input  wire [lc3b_pkg::WORD_W-1:0]    mar,
    input  wire [lc3b_pkg::WORD_W-1:0]    mdr,
    input  wire [lc3b_pkg::CC_W-1:0]      cc,
    input  wire                           ben,
    input  wire [lc3b_pkg::WORD_W-1:0]    sr_base,
    input  wire [lc3b_pkg::WORD_W-1:0]    sr_dst,
    input  wire [lc3b_pkg::WORD_W-1:0]    sr_two,
    output lc3b_pkg::upd_t                upd
);
    import lc3b_pkg::*;

    logic [WORD_W-1:0]  a1;
    logic [WORD_W-1:0]  a2;
    logic [WORD_W-1:0]  a2_off;
    logic [WORD_W-1:0]  adder;
    logic [WORD_W-1:0]  marmux_v;
    logic [WORD_W-1:0]  sr1;
    logic [WORD_W-1:0]  opb;
    logic [WORD_W-1:0]  alu;
    logic [WORD_W-1:0]  shf;
    logic [WORD_W-1:0]  mdr_drv;
    logic [WORD_W-1:0]  bus;
    logic [3:0]         amt;
    logic [STATE_W-1:0] branch_bits;

    always_comb begin
        case (ctrl.addr2mux)
            ADDR2_ZERO: a2_off = '0;
            ADDR2_OFF6: a2_off = {{10{ir[5]}}, ir[5:0]};
            ADDR2_OFF9: a2_off = {{7{ir[8]}}, ir[8:0]};
            default:    a2_off = {{5{ir[10]}}, ir[10:0]};
        endcase
        a2       = ctrl.lshf1 ? {a2_off[WORD_W-2:0], 1'b0} : a2_off;
        a1       = ctrl.addr1mux ? sr_base : pc;
        adder    = a1 + a2;
        // trap vector, zero-extended
        marmux_v = ctrl.marmux ? adder : {7'b0, ir[7:0], 1'b0};

        sr1 = ctrl.sr1mux ? sr_base : sr_dst;
        opb = ir[5] ? {{11{ir[4]}}, ir[4:0]} : sr_two;
        case (ctrl.aluk)
            ALUK_ADD: alu = sr1 + opb;
            ALUK_AND: alu = sr1 & opb;
            ALUK_XOR: alu = sr1 ^ opb;
            default:  alu = sr1;
        endcase

        amt = ir[3:0];
        if (!ir[4]) begin
            shf = sr1 << amt;
        end else if (ir[5]) begin
            shf = WORD_W'($signed(sr1) >>> amt);
        end else begin
            shf = sr1 >> amt;
        end

        if (ctrl.word_op) begin
            mdr_drv = mdr;
        end else if (mar[0]) begin
            mdr_drv = {{8{mdr[15]}}, mdr[15:8]};
        end else begin
            mdr_drv = {{8{mdr[7]}}, mdr[7:0]};
        end

        if (ctrl.drive_alu)         bus = alu;
        else if (ctrl.drive_shf)    bus = shf;
        else if (ctrl.drive_pc)     bus = pc;
        else if (ctrl.drive_mdr)    bus = mdr_drv;
        else if (ctrl.drive_marmux) bus = marmux_v;
        else                        bus = '0;

        branch_bits = {3'b0,
                       ctrl.cond == COND_BEN   && ben,
                       ctrl.cond == COND_READY && mem_rdy,
                       ctrl.cond == COND_IR11  && ir[11]};

        upd.bus      = bus;
        upd.next_upc = ctrl.ird ? {2'b0, ir[15:12]} : (ctrl.j | branch_bits);

        upd.wdata = ctrl.word_op ? mdr : {mdr[7:0], mdr[7:0]};
        upd.we_lo = ctrl.mio_en && ctrl.r_w && (ctrl.word_op || !mar[0]);
        upd.we_hi = ctrl.mio_en && ctrl.r_w && (ctrl.word_op || mar[0]);

        upd.pc = pc;
        if (ctrl.ld_pc) begin
            case (ctrl.pcmux)
                PCMUX_INC: upd.pc = pc + WORD_W'(2);
                PCMUX_BUS: upd.pc = bus;
                default:   upd.pc = adder;
            endcase
        end

        upd.ir  = ctrl.ld_ir ? bus : ir;
        upd.mar = ctrl.ld_mar ? bus : mar;

        upd.cc = cc;
        if (ctrl.ld_cc) begin
            if (bus == '0)  upd.cc = CC_Z;
            else if (bus[WORD_W-1]) upd.cc = CC_N;
            else            upd.cc = CC_P;
        end

        upd.mdr = mdr;
        if (ctrl.ld_mdr) begin
            if (ctrl.mio_en)       upd.mdr = mem_rd;
            else if (ctrl.word_op) upd.mdr = bus;
            else                   upd.mdr = {8'b0, bus[7:0]};
        end

        upd.ben      = ctrl.ld_ben ? |(ir[11:9] & cc) : ben;
        upd.rf_we    = ctrl.ld_reg;
        upd.rf_waddr = ctrl.drmux ? REG_AW'(REG_COUNT - 1) : ir[11:9];
    end

endmodule

`default_nettype wire

// File: hw/rtl/lc3b_microsequencer_datapath.sv
`default_nettype none

// LC-3b microcoded datapath, one machine clock per transfer. Each input transfer
// carries a 35-bit microinstruction, the memory read word and the memory ready
// flag; each produces exactly one result transfer with the next microstate, the
// bus value, the memory address, write data and byte-lane enables, and the PC
// after the step. A transfer is held in the input register and is then
// executed by the combinational datapath logic into the result register, and
// one transfer is taken every cycle while the result side keeps up. The
// register file is three 8x16 RAM copies read at the next IR's fields, with
// write bypass and reset valid bits. Writing cfg_wr_data loads the PC with the
// program base address (reset base is zero).
module lc3b_microsequencer_datapath (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire [15:0]  cfg_wr_data,   // start_pc
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [55:0]  s_tdata,       // control_word[34:0], mem_read_data[50:35],
                                       // mem_ready[51], zero[55:52]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata        // next_state[5:0], bus_value[21:6],
                                       // mem_address[37:22], mem_write_data[53:38],
                                       // mem_write_low[54], mem_write_high[55],
                                       // pc_value[71:56]
);
    import lc3b_pkg::*;

    logic               in_valid_reg;
    logic [CW_W-1:0]    in_cw_reg;
    logic [WORD_W-1:0]  in_rd_reg;
    logic               in_rdy_reg;

    logic [WORD_W-1:0]  pc_reg;
    logic [WORD_W-1:0]  ir_reg;
    logic [WORD_W-1:0]  mar_reg;
    logic [WORD_W-1:0]  mdr_reg;
    logic [CC_W-1:0]    cc_reg;
    logic               ben_reg;

    logic               out_valid_reg;
    logic [71:0]        out_data_reg;

    logic               advance;
    ctrl_t              ctrl;
    upd_t               upd;
    logic [WORD_W-1:0]  ir_next;
    logic [REG_AW-1:0]  rf_raddr [RF_READS];
    logic [WORD_W-1:0]  rf_rdata [RF_READS];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign ctrl     = decode_cw(in_cw_reg);
    assign ir_next  = advance ? upd.ir : ir_reg;

    assign rf_raddr[RD_BASE] = ir_next[8:6];
    assign rf_raddr[RD_DST]  = ir_next[11:9];
    assign rf_raddr[RD_SR2]  = ir_next[2:0];

    lc3b_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (advance && upd.rf_we),
        .waddr   (upd.rf_waddr),
        .wdata   (upd.bus),
        .raddr   (rf_raddr),
        .rdata   (rf_rdata)
    );

    lc3b_exec u_exec (
        .ctrl    (ctrl),
        .mem_rd  (in_rd_reg),
        .mem_rdy (in_rdy_reg),
        .pc      (pc_reg),
        .ir      (ir_reg),
        .mar     (mar_reg),
        .mdr     (mdr_reg),
        .cc      (cc_reg),
        .ben     (ben_reg),
        .sr_base (rf_rdata[RD_BASE]),
        .sr_dst  (rf_rdata[RD_DST]),
        .sr_two  (rf_rdata[RD_SR2]),
        .upd     (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cw_reg  <= s_tdata[34:0];
            in_rd_reg  <= s_tdata[50:35];
            in_rdy_reg <= s_tdata[51];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= '0;
            ir_reg  <= '0;
            mar_reg <= '0;
            mdr_reg <= '0;
            cc_reg  <= CC_Z;
            ben_reg <= 1'b0;
        end else begin
            if (advance) begin
                pc_reg  <= upd.pc;
                ir_reg  <= upd.ir;
                mar_reg <= upd.mar;
                mdr_reg <= upd.mdr;
                cc_reg  <= upd.cc;
                ben_reg <= upd.ben;
            end
            if (cfg_wr_en) begin
                pc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= {upd.pc, upd.we_hi, upd.we_lo, upd.wdata,
                             mar_reg, upd.bus, upd.next_upc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lc3b_checker.sv
`default_nettype none

`include "assert_macros.svh"

module lc3b_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [71:0]  m_tdata
);

    logic out_stall;
    logic byte_store;
    logic mirrored;

    assign out_stall  = m_tvalid && !m_tready;
    assign byte_store = m_tvalid && (m_tdata[54] != m_tdata[55]);
    assign mirrored   = (m_tdata[53:46] == m_tdata[45:38]);

    `ASSERT_CLKED(a_out_hold, aclk, aresetn, out_stall |=> m_tvalid, "result dropped")
    `ASSERT_CLKED(a_out_stable, aclk, aresetn, out_stall |=> $stable(m_tdata), "result changed")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready, "busy after reset")
    `ASSERT_CLKED(a_stall_cause, aclk, aresetn, !s_tready |-> out_stall, "input stalled")
    `ASSERT_CLKED(a_byte_mirror, aclk, aresetn, byte_store |-> mirrored, "byte not mirrored")

endmodule

bind lc3b_microsequencer_datapath lc3b_checker u_lc3b_checker (.*);

`default_nettype wire

// File: bench/lc3b_datapath_checker.sv
module lc3b_datapath_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire [15:0]  cfg_wr_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [55:0]  s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [71:0]  m_tdata,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);
    import lc3b_pkg::*;

    localparam logic [REG_AW-1:0] LINK_REG  = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0]  pc_value;
        logic               we_hi;
        logic               we_lo;
        logic [WORD_W-1:0]  wdata;
        logic [WORD_W-1:0]  addr;
        logic [WORD_W-1:0]  bus;
        logic [STATE_W-1:0] next_upc;
    } step_result_t;

    logic [WORD_W-1:0] pc, ir, mar, mdr;
    logic [WORD_W-1:0] regs [REG_COUNT];
    logic [CC_W-1:0]   cc;
    logic              ben;

    step_result_t due_results[$];
    step_result_t got, want;
    int fails = 0;
    int checked = 0;
    int queued = 0;

    assign mismatches      = fails;
    assign outstanding     = queued;
    assign results_checked = checked;

    function automatic step_result_t execute_microinstruction(
        input logic [CW_W-1:0] cw, input logic [WORD_W-1:0] rd, input logic rdy);
        ctrl_t c;
        step_result_t r;
        logic [WORD_W-1:0] cur_ir, a1, a2, adder, marmux_v, sr1, opb, alu, shf, mdr_drv, bus;
        logic [CC_W-1:0] old_cc;
        logic [REG_AW-1:0] dst;
        c.ird          = cw[0];
        c.cond         = {cw[1], cw[2]};
        c.j            = {cw[3], cw[4], cw[5], cw[6], cw[7], cw[8]};
        c.ld_mar       = cw[9];
        c.ld_mdr       = cw[10];
        c.ld_ir        = cw[11];
        c.ld_ben       = cw[12];
        c.ld_reg       = cw[13];
        c.ld_cc        = cw[14];
        c.ld_pc        = cw[15];
        c.drive_pc     = cw[16];
        c.drive_mdr    = cw[17];
        c.drive_alu    = cw[18];
        c.drive_marmux = cw[19];
        c.drive_shf    = cw[20];
        c.pcmux        = {cw[21], cw[22]};
        c.drmux        = cw[23];
        c.sr1mux       = cw[24];
        c.addr1mux     = cw[25];
        c.addr2mux     = {cw[26], cw[27]};
        c.marmux       = cw[28];
        c.aluk         = {cw[29], cw[30]};
        c.mio_en       = cw[31];
        c.r_w          = cw[32];
        c.word_op      = cw[33];
        c.lshf1        = cw[34];
        cur_ir = ir;
        old_cc = cc;

        if (c.ird) begin
            r.next_upc = {2'b00, cur_ir[15:12]};
        end else begin
            r.next_upc = c.j;
            if (c.cond == COND_BEN && ben) r.next_upc[2] = 1'b1;
            if (c.cond == COND_READY && rdy) r.next_upc[1] = 1'b1;
            if (c.cond == COND_IR11 && cur_ir[11]) r.next_upc[0] = 1'b1;
        end

        case (c.addr2mux)
            ADDR2_ZERO: a2 = '0;
            ADDR2_OFF6: a2 = {{10{cur_ir[5]}}, cur_ir[5:0]};
            ADDR2_OFF9: a2 = {{7{cur_ir[8]}}, cur_ir[8:0]};
            default:    a2 = {{5{cur_ir[10]}}, cur_ir[10:0]};
        endcase
        if (c.lshf1) a2 = {a2[14:0], 1'b0};
        a1 = c.addr1mux ? regs[cur_ir[8:6]] : pc;
        adder = a1 + a2;
        marmux_v = c.marmux ? adder : {7'b0, cur_ir[7:0], 1'b0};

        sr1 = c.sr1mux ? regs[cur_ir[8:6]] : regs[cur_ir[11:9]];
        opb = cur_ir[5] ? {{11{cur_ir[4]}}, cur_ir[4:0]} : regs[cur_ir[2:0]];
        case (c.aluk)
            ALUK_ADD: alu = sr1 + opb;
            ALUK_AND: alu = sr1 & opb;
            ALUK_XOR: alu = sr1 ^ opb;
            default:  alu = sr1;
        endcase

        if (!cur_ir[4])
            shf = sr1 << cur_ir[3:0];
        else if (cur_ir[5])
            shf = $signed(sr1) >>> cur_ir[3:0];
        else
            shf = sr1 >> cur_ir[3:0];

        if (c.word_op)
            mdr_drv = mdr;
        else if (mar[0])
            mdr_drv = {{8{mdr[15]}}, mdr[15:8]};
        else
            mdr_drv = {{8{mdr[7]}}, mdr[7:0]};

        if (c.drive_alu)         bus = alu;
        else if (c.drive_shf)    bus = shf;
        else if (c.drive_pc)     bus = pc;
        else if (c.drive_mdr)    bus = mdr_drv;
        else if (c.drive_marmux) bus = marmux_v;
        else                     bus = '0;

        r.bus   = bus;
        r.addr  = mar;
        r.wdata = c.word_op ? mdr : {mdr[7:0], mdr[7:0]};
        r.we_lo = c.mio_en && c.r_w && (c.word_op || !mar[0]);
        r.we_hi = c.mio_en && c.r_w && (c.word_op || mar[0]);

        if (c.ld_pc) begin
            if (c.pcmux == PCMUX_INC)      pc = pc + 16'd2;
            else if (c.pcmux == PCMUX_BUS) pc = bus;
            else                           pc = adder;
        end
        if (c.ld_ir) ir = bus;
        if (c.ld_cc) begin
            if (bus == '0)   cc = CC_Z;
            else if (bus[15]) cc = CC_N;
            else             cc = CC_P;
        end
        if (c.ld_mdr) begin
            if (c.mio_en)       mdr = rd;
            else if (c.word_op) mdr = bus;
            else                mdr = {8'b0, bus[7:0]};
        end
        if (c.ld_mar) mar = bus;
        if (c.ld_reg) begin
            dst = c.drmux ? LINK_REG : cur_ir[11:9];
            regs[dst] = bus;
        end
        if (c.ld_ben) ben = |(cur_ir[11:9] & old_cc);
        r.pc_value = pc;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pc = '0;
            ir = '0;
            mar = '0;
            mdr = '0;
            for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
            cc = CC_Z;
            ben = 1'b0;
            due_results.delete();
        end else begin
            // result side first: a result never belongs to a transfer taken at the same edge
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result transfer %h", m_tdata);
                end else begin
                    want = due_results.pop_front();
                    checked++;
                    if (got.next_upc !== want.next_upc || got.bus !== want.bus ||
                        got.addr !== want.addr || got.wdata !== want.wdata ||
                        got.we_lo !== want.we_lo || got.we_hi !== want.we_hi ||
                        got.pc_value !== want.pc_value) begin
                        fails++;
                        if (fails <= 10)
                            $display({"result %0d mismatch (exp/act): state %h/%h bus %h/%h",
                                      " addr %h/%h wdata %h/%h we %b%b/%b%b pc %h/%h"},
                                     checked, want.next_upc, got.next_upc,
                                     want.bus, got.bus, want.addr, got.addr,
                                     want.wdata, got.wdata, want.we_hi, want.we_lo,
                                     got.we_hi, got.we_lo, want.pc_value, got.pc_value);
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(execute_microinstruction(
                    s_tdata[34:0], s_tdata[50:35], s_tdata[51]));
            if (cfg_wr_en)
                pc = cfg_wr_data;
        end
        queued = due_results.size();
    end

endmodule

// File: bench/tb_lc3b_microsequencer_datapath.sv
module tb_lc3b_microsequencer_datapath;
    import lc3b_pkg::*;

    localparam logic [1:0] PCMUX_ADDER     = 2'd2;
    localparam logic [1:0] PCMUX_ADDER_ALT = 2'd3;
    localparam logic [1:0] ALUK_PASS       = 2'd3;
    localparam int         HOLD_CYCLES     = 80;

    typedef enum int {
        UOP_FETCH_MAR, UOP_FETCH_MDR, UOP_FETCH_IR, UOP_DECODE,
        UOP_ALU, UOP_SHIFT, UOP_LEA, UOP_BRANCH, UOP_JUMP, UOP_TRAP,
        UOP_STORE_ADDR, UOP_STORE_DATA, UOP_STORE_MEM, UOP_LOAD_MEM, UOP_LOAD_REG
    } uop_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [55:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [71:0] m_tdata;

    int mismatches, outstanding, results_checked;
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_asks = 0;
    int holds_done = 0;
    int hold_left = 0;
    int sent_items = 0;
    int base_writes = 0;

    lc3b_microsequencer_datapath u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    lc3b_datapath_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stalls, plus long holds on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (holds_done < hold_asks) begin
            holds_done = holds_done + 1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin
        #2_000_000;
        $display("timeout waiting on the datapath");
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [CW_W-1:0] pack_cw(input ctrl_t c);
        logic [CW_W-1:0] cw;
        cw[0] = c.ird;
        cw[1] = c.cond[1];
        cw[2] = c.cond[0];
        for (int k = 0; k < 6; k++) cw[3+k] = c.j[5-k];
        cw[9]  = c.ld_mar;
        cw[10] = c.ld_mdr;
        cw[11] = c.ld_ir;
        cw[12] = c.ld_ben;
        cw[13] = c.ld_reg;
        cw[14] = c.ld_cc;
        cw[15] = c.ld_pc;
        cw[16] = c.drive_pc;
        cw[17] = c.drive_mdr;
        cw[18] = c.drive_alu;
        cw[19] = c.drive_marmux;
        cw[20] = c.drive_shf;
        cw[21] = c.pcmux[1];
        cw[22] = c.pcmux[0];
        cw[23] = c.drmux;
        cw[24] = c.sr1mux;
        cw[25] = c.addr1mux;
        cw[26] = c.addr2mux[1];
        cw[27] = c.addr2mux[0];
        cw[28] = c.marmux;
        cw[29] = c.aluk[1];
        cw[30] = c.aluk[0];
        cw[31] = c.mio_en;
        cw[32] = c.r_w;
        cw[33] = c.word_op;
        cw[34] = c.lshf1;
        return cw;
    endfunction

    function automatic ctrl_t make_uop(input uop_kind_t kind, input logic [1:0] sel);
        ctrl_t c;
        c = '0;
        c.j = STATE_W'($urandom);
        c.cond = 2'($urandom);
        case (kind)
            UOP_FETCH_MAR: begin
                c.ld_mar = 1'b1; c.drive_pc = 1'b1; c.ld_pc = 1'b1; c.pcmux = PCMUX_INC;
            end
            UOP_FETCH_MDR: begin
                c.ld_mdr = 1'b1; c.mio_en = 1'b1; c.word_op = 1'b1; c.cond = COND_READY;
            end
            UOP_FETCH_IR: begin
                c.ld_ir = 1'b1; c.drive_mdr = 1'b1; c.word_op = 1'b1;
            end
            UOP_DECODE: begin
                c.ld_ben = 1'b1; c.ird = 1'b1;
            end
            UOP_ALU: begin
                c.ld_reg = 1'b1; c.ld_cc = 1'b1; c.drive_alu = 1'b1; c.aluk = sel;
                c.sr1mux = 1'($urandom); c.drmux = 1'($urandom);
            end
            UOP_SHIFT: begin
                c.ld_reg = 1'b1; c.ld_cc = 1'b1; c.drive_shf = 1'b1;
                c.sr1mux = 1'($urandom);
            end
            UOP_LEA: begin
                c.ld_reg = 1'b1; c.ld_cc = 1'($urandom); c.drive_marmux = 1'b1;
                c.marmux = 1'b1; c.addr1mux = 1'($urandom); c.addr2mux = sel;
                c.lshf1 = 1'b1;
            end
            UOP_BRANCH: begin
                c.ld_pc = 1'b1; c.pcmux = sel[0] ? PCMUX_ADDER_ALT : PCMUX_ADDER;
                c.addr1mux = sel[1]; c.addr2mux = sel; c.lshf1 = 1'($urandom);
                c.cond = COND_BEN;
            end
            UOP_JUMP: begin
                c.ld_pc = 1'b1; c.pcmux = PCMUX_BUS; c.drive_alu = 1'b1;
                c.aluk = ALUK_PASS; c.sr1mux = 1'b1;
            end
            UOP_TRAP: begin
                c.ld_mar = 1'b1; c.drive_marmux = 1'b1; c.marmux = 1'b0;
                c.ld_reg = 1'($urandom); c.drmux = 1'b1;
            end
            UOP_STORE_ADDR: begin
                c.ld_mar = 1'b1; c.drive_marmux = 1'b1; c.marmux = 1'b1;
                c.addr1mux = 1'b1; c.addr2mux = ADDR2_OFF6; c.lshf1 = sel[0];
            end
            UOP_STORE_DATA: begin
                c.ld_mdr = 1'b1; c.drive_alu = 1'b1; c.aluk = ALUK_PASS; c.word_op = sel[0];
            end
            UOP_STORE_MEM: begin
                c.mio_en = 1'b1; c.r_w = 1'b1; c.word_op = sel[0]; c.cond = COND_READY;
            end
            UOP_LOAD_MEM: begin
                c.ld_mdr = 1'b1; c.mio_en = 1'b1; c.word_op = sel[0]; c.cond = COND_READY;
            end
            default: begin
                c.ld_reg = 1'b1; c.ld_cc = 1'b1; c.drive_mdr = 1'b1; c.word_op = sel[0];
            end
        endcase
        return c;
    endfunction

    task automatic send(input logic [CW_W-1:0] cw, input logic [15:0] rd, input logic rdy);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, rdy, rd, cw};
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic send_uop(input uop_kind_t kind, input logic [1:0] sel,
                            input logic [15:0] rd, input logic rdy);
        send(pack_cw(make_uop(kind, sel)), rd, rdy);
    endtask

    task automatic run_instruction();
        int n_exec;
        n_exec = $urandom_range(1, 3);
        send_uop(UOP_FETCH_MAR, 2'($urandom), 16'($urandom), 1'($urandom));
        while ($urandom_range(3) == 0)
            send_uop(UOP_FETCH_MDR, 2'($urandom), 16'($urandom), 1'b0);
        send_uop(UOP_FETCH_MDR, 2'($urandom), 16'($urandom), 1'b1);
        send_uop(UOP_FETCH_IR, 2'($urandom), 16'($urandom), 1'($urandom));
        send_uop(UOP_DECODE, 2'($urandom), 16'($urandom), 1'($urandom));
        repeat (n_exec)
            send_uop(uop_kind_t'($urandom_range(UOP_ALU, UOP_LOAD_REG)), 2'($urandom),
                     16'($urandom), 1'($urandom));
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = sent_items + count;
        while (sent_items < goal) begin
            if ($urandom_range(99) < 20)
                send(CW_W'({$urandom, $urandom}), 16'($urandom), 1'($urandom));
            else
                run_instruction();
        end
    endtask

    task automatic run_directed();
        send('0, 16'h0000, 1'b0);
        send('1, 16'hFFFF, 1'b1);
        send_uop(UOP_FETCH_MAR, 2'd0, 16'h8000, 1'b0);
        // MDR loads from memory even before ready
        send_uop(UOP_FETCH_MDR, 2'd0, 16'hD035, 1'b0);
        send_uop(UOP_FETCH_MDR, 2'd0, 16'hD035, 1'b1);
        send_uop(UOP_FETCH_IR, 2'd0, 16'h0000, 1'b0);
        send_uop(UOP_DECODE, 2'd0, 16'h0000, 1'b0);
        for (int s = 0; s < 4; s++) send_uop(UOP_ALU, 2'(s), 16'hFFFF, 1'b1);
        send_uop(UOP_SHIFT, 2'd0, 16'h7FFF, 1'b0);
        for (int s = 0; s < 4; s++) send_uop(UOP_BRANCH, 2'(s), 16'h0001, 1'b1);
        send_uop(UOP_JUMP, 2'd0, 16'h0000, 1'b0);
        send_uop(UOP_TRAP, 2'd0, 16'h0000, 1'b0);
        send_uop(UOP_LEA, ADDR2_OFF9, 16'h0000, 1'b0);
        send_uop(UOP_STORE_ADDR, 2'd1, 16'h0000, 1'b0);
        send_uop(UOP_STORE_DATA, 2'd0, 16'h0000, 1'b0);
        send_uop(UOP_STORE_MEM, 2'd0, 16'h0000, 1'b1);
        send_uop(UOP_STORE_MEM, 2'd1, 16'h0000, 1'b1);
        send_uop(UOP_LOAD_MEM, 2'd0, 16'h80FF, 1'b1);
        send_uop(UOP_LOAD_REG, 2'd0, 16'h0000, 1'b0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        @(negedge aclk);
    endtask

    task automatic write_start_pc(input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        base_writes++;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_start_pc(16'h0000);
        tx_idle = 35;
        rx_idle = 56;
        run_directed();
        run_random(200);
        hold_asks++;
        run_random(200);
        drain();

        write_start_pc(16'hFFFF);
        tx_idle = 56;
        rx_idle = 35;
        run_random(410);
        drain();

        write_start_pc(16'($urandom));
        tx_idle = 0;
        rx_idle = 0;
        run_random(200);
        hold_asks++;
        run_random(215);
        drain();
        repeat (4) @(negedge aclk);

        $display("%0d microinstructions sent over three stall mixes with long output holds,",
                 sent_items);
        $display("%0d results checked, start_pc written %0d times", results_checked,
                 base_writes);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
